// File: sv/sast_pkg.sv
// Package with types and constants of the source abuse score table.
package sast_pkg;
   localparam int ENTRY_W = 64 + 64 + 1 + 10 + 32 + 1;
   localparam logic [9:0] BLOCK_LEVEL = 10'd100;
   localparam logic [9:0] SCORE_MAX = 10'd1023;

   typedef enum logic [2:0] {
      ACT_ALLOW = 3'd0,
      ACT_RECORD = 3'd1,
      ACT_HOLD = 3'd2,
      ACT_BLOCK = 3'd3,
      ACT_FULL = 3'd4,
      ACT_PRUNE = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      REG_EXPIRE = 3'd0,
      REG_V6EN = 3'd1,
      REG_ADDR_A = 3'd2,
      REG_LEN_A = 3'd3,
      REG_ADDR_B = 3'd4,
      REG_LEN_B = 3'd5,
      REG_ADDR_C = 3'd6,
      REG_LEN_C = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_WRITE, ST_PRUNE, ST_OUT
   } state_type;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic v6;
      logic [9:0] score;
      logic [31:0] seen;
      logic blocked;
   } entry_type;

   function automatic logic prefix_hit(logic [31:0] a, logic [31:0] p, logic [5:0] len);
      logic [31:0] mask;
      logic [5:0] l;
      begin
         l = (len > 6'd32) ? 6'd32 : len;
         mask = ~(32'hFFFF_FFFF >> l);
         prefix_hit = (len != 6'd0) && (((a ^ p) & mask) == 32'd0);
      end
   endfunction
endpackage

// File: sv/sast_ram.sv
// Generic single-port-write, registered-read RAM.
module sast_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/source_abuse_score_table.sv
// Top level of the source abuse score table.
//
//   channel   direction  handshake               contents
//   req_      in         req_valid / req_ready   command, address, weight, hold, time
//   rsp_      out        rsp_valid / rsp_ready   action, hold_time, score, removed_count
//   csr_      in         csr_valid / csr_ready   register index and write data
//
// An event and a prune each walk through the entry RAM one entry a cycle, and a whitelisted
// word skips the walk and goes straight to the result.
// Valid bits are flip-flops that reset clears at once, so no clearing pass is needed.
// Reset also restores the register defaults; a waiting result holds until rsp_ready.
module source_abuse_score_table
   import sast_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_command,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic req_is_v6,
   input  logic [7:0] req_weight,
   input  logic [15:0] req_hold_seconds,
   input  logic [31:0] req_now_seconds,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_action,
   output logic [15:0] rsp_hold_time,
   output logic [9:0] rsp_score,
   output logic [8:0] rsp_removed_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [30:0] expire_ff;
   logic v6en_ff;
   logic [31:0] aa_ff, ab_ff, ac_ff;
   logic [5:0] la_ff, lb_ff, lc_ff;

   state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic [63:0] hi_ff, lo_ff;
   logic v6_ff;
   logic [7:0] w_ff;
   logic [15:0] hold_ff;
   logic [31:0] now_ff;
   logic found_ff, found_in, free_ok_ff, free_ok_in;
   logic [AW-1:0] slot_ff, slot_in, free_ff, free_in;
   entry_type hit_ff, hit_in;
   logic [8:0] rem_ff, rem_in;
   logic [2:0] act_ff, act_in;
   logic [15:0] ohold_ff, ohold_in;
   logic [9:0] osc_ff, osc_in;

   logic wr_en;
   logic [AW-1:0] rd_addr, rd_idx, wr_addr;
   entry_type rd_ent, wr_ent;
   logic [ENTRY_W-1:0] rd_raw;
   logic [10:0] sum;
   logic [9:0] sc;
   logic may_block, rd_valid;
   logic [31:0] age;

   sast_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_ent),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );
   assign rd_ent = entry_type'(rd_raw);

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_action = act_ff;
   assign rsp_hold_time = ohold_ff;
   assign rsp_score = osc_ff;
   assign rsp_removed_count = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expire_ff <= 31'd3600;
         v6en_ff <= 1'b1;
         aa_ff <= 32'h7F00_0001;
         la_ff <= 6'd32;
         ab_ff <= 32'hC0A8_0000;
         lb_ff <= 6'd16;
         ac_ff <= 32'h0A00_0000;
         lc_ff <= 6'd8;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_EXPIRE: expire_ff <= csr_data[30:0];
            REG_V6EN: v6en_ff <= csr_data[0];
            REG_ADDR_A: aa_ff <= csr_data;
            REG_LEN_A: la_ff <= csr_data[5:0];
            REG_ADDR_B: ab_ff <= csr_data;
            REG_LEN_B: lb_ff <= csr_data[5:0];
            REG_ADDR_C: ac_ff <= csr_data;
            REG_LEN_C: lc_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      found_ff <= found_in;
      free_ok_ff <= free_ok_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      hit_ff <= hit_in;
      rem_ff <= rem_in;
      act_ff <= act_in;
      ohold_ff <= ohold_in;
      osc_ff <= osc_in;
      if (req_valid && req_ready) begin
         v6_ff <= req_is_v6;
         hi_ff <= req_is_v6 ? req_addr_hi : 64'd0;
         lo_ff <= req_is_v6 ? req_addr_lo : {32'd0, req_addr_lo[31:0]};
         w_ff <= req_weight;
         hold_ff <= req_hold_seconds;
         now_ff <= req_now_seconds;
      end
   end

   // The read address runs one entry ahead of the entry being checked, since the RAM read is registered.
   assign rd_idx = cnt_ff[AW-1:0] - AW'(1);
   assign rd_valid = valid_ff[rd_idx];
   assign age = now_ff - rd_ent.seen;
   assign sum = {1'b0, (found_ff ? hit_ff.score : 10'd0)} + {3'd0, w_ff};
   assign sc = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[9:0];
   assign may_block = !v6_ff || v6en_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      found_in = found_ff;
      free_ok_in = free_ok_ff;
      slot_in = slot_ff;
      free_in = free_ff;
      hit_in = hit_ff;
      rem_in = rem_ff;
      act_in = act_ff;
      ohold_in = ohold_ff;
      osc_in = osc_ff;
      rd_addr = cnt_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_ent = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            cnt_in = (AW+1)'(1);
            found_in = 1'b0;
            free_ok_in = 1'b0;
            rem_in = '0;
            ohold_in = '0;
            osc_in = '0;
            if (req_valid) begin
               if (req_command) begin
                  state_in = ST_PRUNE;
               end else if (!req_is_v6 && (prefix_hit(req_addr_lo[31:0], aa_ff, la_ff) ||
                     prefix_hit(req_addr_lo[31:0], ab_ff, lb_ff) ||
                     prefix_hit(req_addr_lo[31:0], ac_ff, lc_ff))) begin
                  act_in = ACT_ALLOW;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_valid) begin
               if (!found_in && rd_ent.v6 == v6_ff && rd_ent.hi == hi_ff &&
                     rd_ent.lo == lo_ff) begin
                  found_in = 1'b1;
                  slot_in = rd_idx;
                  hit_in = rd_ent;
               end
            end else if (!free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in = rd_idx;
            end
            cnt_in = cnt_ff + (AW+1)'(1);
            if (cnt_ff == (AW+1)'(TABLE_DEPTH)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_OUT;
            osc_in = sc;
            if (!found_ff && !free_ok_ff) begin
               act_in = ACT_FULL;
               osc_in = '0;
            end else begin
               wr_en = 1'b1;
               wr_addr = found_ff ? slot_ff : free_ff;
               wr_ent.hi = hi_ff;
               wr_ent.lo = lo_ff;
               wr_ent.v6 = v6_ff;
               wr_ent.score = sc;
               wr_ent.seen = now_ff;
               wr_ent.blocked = found_ff && hit_ff.blocked;
               valid_in[wr_addr] = 1'b1;
               if (found_ff && hit_ff.blocked) begin
                  act_in = ACT_RECORD;
               end else if (may_block && sc >= BLOCK_LEVEL) begin
                  wr_ent.blocked = 1'b1;
                  act_in = ACT_BLOCK;
               end else if (may_block && hold_ff != 16'd0) begin
                  act_in = ACT_HOLD;
                  ohold_in = hold_ff;
               end else begin
                  act_in = ACT_RECORD;
               end
            end
         end
         ST_PRUNE: begin
            if (rd_valid && (age > {1'b0, expire_ff} ||
                  (rd_ent.blocked && age > {2'b0, expire_ff[30:1]}))) begin
               valid_in[rd_idx] = 1'b0;
               rem_in = rem_ff + 9'd1;
            end
            cnt_in = cnt_ff + (AW+1)'(1);
            if (cnt_ff == (AW+1)'(TABLE_DEPTH)) begin
               act_in = ACT_PRUNE;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and result sides both open");
   a_prune_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_PRUNE |-> rsp_removed_count == 9'd0)
      else $error("removed count outside prune");
   a_hold_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_HOLD |-> rsp_hold_time == 16'd0)
      else $error("hold time without hold");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_WRITE) else $error("table written outside write step");
endmodule

// File: tb/source_abuse_score_table_test.sv
// Self-checking testbench of the source abuse score table with a class scoreboard.
module source_abuse_score_table_test
   import sast_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;

   typedef struct packed {
      logic cmd;
      logic [63:0] hi;
      logic [63:0] lo;
      logic v6;
      logic [7:0] weight;
      logic [15:0] hold;
      logic [31:0] now;
   } word_type;

   typedef struct packed {
      logic [2:0] action;
      logic [15:0] hold_time;
      logic [9:0] score;
      logic [8:0] removed;
   } verdict_type;

   class score_board;
      logic [30:0] expire;
      logic v6en;
      logic [31:0] allow_addr [3];
      logic [5:0] allow_len [3];
      logic live [DEPTH];
      entry_type tab [DEPTH];
      verdict_type pending [$];
      int errors;

      function new();
         expire = 31'd3600;
         v6en = 1'b1;
         allow_addr[0] = 32'd2130706433;
         allow_len[0] = 6'd32;
         allow_addr[1] = 32'd3232235520;
         allow_len[1] = 6'd16;
         allow_addr[2] = 32'd167772160;
         allow_len[2] = 6'd8;
         foreach (live[i]) live[i] = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] d);
         case (idx)
            REG_EXPIRE: expire = d[30:0];
            REG_V6EN: v6en = d[0];
            REG_ADDR_A: allow_addr[0] = d;
            REG_LEN_A: allow_len[0] = d[5:0];
            REG_ADDR_B: allow_addr[1] = d;
            REG_LEN_B: allow_len[1] = d[5:0];
            REG_ADDR_C: allow_addr[2] = d;
            REG_LEN_C: allow_len[2] = d[5:0];
         endcase
      endfunction

      function logic allowed(logic [31:0] a);
         logic [31:0] mask;
         int l;
         for (int k = 0; k < 3; k++) begin
            l = int'(allow_len[k]);
            if (l == 0) continue;
            if (l > 32) l = 32;
            mask = (l == 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> l);
            if (((a ^ allow_addr[k]) & mask) == 0) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_word(word_type w);
         verdict_type v;
         logic [63:0] hi, lo;
         logic [31:0] age;
         logic [10:0] sum;
         logic [9:0] sc;
         logic may_block;
         int slot, free_slot, removed;
         v = '0;
         slot = -1;
         free_slot = -1;
         removed = 0;
         if (w.cmd) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!live[i]) continue;
               age = w.now - tab[i].seen;
               if (age > {1'b0, expire} || (tab[i].blocked && age > {2'b0, expire[30:1]})) begin
                  live[i] = 1'b0;
                  removed++;
               end
            end
            v.action = ACT_PRUNE;
            v.removed = removed[8:0];
            pending.push_back(v);
            return;
         end
         hi = w.v6 ? w.hi : 64'd0;
         lo = w.v6 ? w.lo : {32'd0, w.lo[31:0]};
         if (!w.v6 && allowed(lo[31:0])) begin
            v.action = ACT_ALLOW;
            pending.push_back(v);
            return;
         end
         for (int i = 0; i < DEPTH; i++) begin
            if (live[i]) begin
               if (slot < 0 && tab[i].v6 == w.v6 && tab[i].hi == hi && tab[i].lo == lo)
                  slot = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (slot >= 0) begin
            sum = {1'b0, tab[slot].score} + {3'd0, w.weight};
            sc = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[9:0];
            tab[slot].score = sc;
            tab[slot].seen = w.now;
            if (tab[slot].blocked) begin
               v.action = ACT_RECORD;
               v.score = sc;
               pending.push_back(v);
               return;
            end
         end else begin
            if (free_slot < 0) begin
               v.action = ACT_FULL;
               pending.push_back(v);
               return;
            end
            slot = free_slot;
            sc = {2'b0, w.weight};
            live[slot] = 1'b1;
            tab[slot] = '{hi: hi, lo: lo, v6: w.v6, score: sc, seen: w.now, blocked: 1'b0};
         end
         may_block = !w.v6 || v6en;
         v.score = sc;
         if (may_block && sc >= BLOCK_LEVEL) begin
            tab[slot].blocked = 1'b1;
            v.action = ACT_BLOCK;
         end else if (may_block && w.hold != 0) begin
            v.action = ACT_HOLD;
            v.hold_time = w.hold;
         end else begin
            v.action = ACT_RECORD;
         end
         pending.push_back(v);
      endfunction

      function void check_result(verdict_type got);
         verdict_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %p", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, actual %p", exp, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [63:0] req_addr_hi = '0;
   logic [63:0] req_addr_lo = '0;
   logic req_is_v6 = 1'b0;
   logic [7:0] req_weight = '0;
   logic [15:0] req_hold_seconds = '0;
   logic [31:0] req_now_seconds = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_action;
   logic [15:0] rsp_hold_time;
   logic [9:0] rsp_score;
   logic [8:0] rsp_removed_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   score_board board;
   int send_idle = 0;
   int recv_idle = 0;
   logic stall_go = 1'b0;
   logic long_stall = 1'b0;
   logic [31:0] clock_now = 32'd1000;
   word_type pool [$];

   source_abuse_score_table u_top (.*);

   always #10 clock = ~clock;

   initial begin
      wait (stall_go);
      long_stall <= 1'b1;
      repeat (3000) @(posedge clock);
      long_stall <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_stall) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
      if (!reset && rsp_valid && rsp_ready)
         board.check_result('{rsp_action, rsp_hold_time, rsp_score, rsp_removed_count});
   end

   task automatic send_word(word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_command, req_addr_hi, req_addr_lo, req_is_v6, req_weight, req_hold_seconds,
         req_now_seconds} <= w;
      do @(posedge clock); while (!req_ready);
      board.note_word(w);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
   endtask

   function automatic word_type event_word(logic [63:0] hi, logic [63:0] lo, logic v6,
                                          logic [7:0] wt, logic [15:0] hd);
      clock_now = clock_now + $urandom_range(40);
      return '{cmd: 1'b0, hi: hi, lo: lo, v6: v6, weight: wt, hold: hd, now: clock_now};
   endfunction

   function automatic word_type prune_word(logic [31:0] step);
      word_type w;
      clock_now = clock_now + step;
      w.cmd = 1'b1;
      w.hi = {$urandom, $urandom};
      w.lo = {$urandom, $urandom};
      w.v6 = 1'($urandom);
      w.weight = 8'($urandom);
      w.hold = 16'($urandom);
      w.now = clock_now;
      return w;
   endfunction

   function automatic word_type random_word();
      word_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return prune_word($urandom_range(pick < 2 ? 4000 : 300));
      if (pool.size() > 0 && pick < 60)
         w = pool[$urandom_range(pool.size() - 1)];
      else begin
         w = '0;
         w.hi = {$urandom, $urandom};
         w.lo = {$urandom, $urandom};
         w.v6 = 1'($urandom);
         if ($urandom_range(3) != 0) w.hi = {56'd0, w.hi[7:0]};
         if (!w.v6 && $urandom_range(3) == 0) w.lo[31:24] = 8'd10;
         w.lo[63:32] = $urandom;
         pool.push_back(w);
         if (pool.size() > 300) void'(pool.pop_front());
      end
      w.weight = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(30));
      w.hold = ($urandom_range(1)) ? 16'd0 : 16'($urandom);
      return event_word(w.hi, w.lo, w.v6, w.weight, w.hold);
   endfunction

   initial begin
      #50ms;
      $display("source_abuse_score_table_test NOT OK");
      $finish;
   end

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(event_word(64'hFFFF, 64'hFFFF_FFFF_7F00_0001, 1'b0, 8'd5, 16'd9));
      send_word(event_word(64'd0, 64'h0A12_3456, 1'b0, 8'd5, 16'd0));
      send_word(event_word(64'd0, 64'hC0A8_FFFF, 1'b0, 8'd5, 16'd0));
      send_word(event_word(64'd0, 64'hC0A9_0001, 1'b0, 8'd0, 16'd0));
      send_word(event_word(64'hDEAD, 64'hC0A9_0001, 1'b0, 8'd99, 16'hFFFF));
      send_word(event_word(64'd0, 64'hC0A9_0001, 1'b0, 8'd255, 16'd7));
      send_word(event_word(64'd0, 64'hC0A9_0001, 1'b0, 8'd255, 16'd7));
      for (int i = 0; i < 4; i++)
         send_word(event_word(64'd0, 64'h0B00_0000, 1'b0, 8'd255, 16'd0));
      send_word(event_word('1, '1, 1'b1, 8'd50, 16'd1));
      send_word(event_word('1, '1, 1'b1, 8'd50, 16'd1));
      send_word(event_word(64'd0, 64'h7F00_0001, 1'b1, 8'd1, 16'd0));
      send_word(prune_word(32'd1000));
      send_word(prune_word(32'd4000));
      drain();

      write_reg(REG_V6EN, 32'd0);
      write_reg(REG_LEN_A, 32'd63);
      write_reg(REG_ADDR_A, 32'hFFFF_FFFF);
      write_reg(REG_LEN_B, 32'd0);
      write_reg(REG_ADDR_B, 32'd0);
      write_reg(REG_LEN_C, 32'd1);
      write_reg(REG_ADDR_C, 32'h8000_0000);
      write_reg(REG_EXPIRE, 32'h7FFF_FFFF);
      send_word(event_word(64'd7, 64'd7, 1'b1, 8'd200, 16'd5));
      send_word(event_word(64'd0, 64'hFFFF_FFFF, 1'b0, 8'd1, 16'd0));
      send_word(event_word(64'd0, 64'h9000_0000, 1'b0, 8'd1, 16'd0));
      for (int i = 0; i < DEPTH + 2; i++)
         send_word(event_word(64'd0, 64'(i + 1), 1'b0, 8'd1, 16'd0));
      send_word(prune_word(32'hFFFF_FFF0));
      send_word(prune_word(32'h8000_0000));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? (phase == 3 ? 6 : 46) : 0;
         recv_idle = (phase == 2 || phase == 3) ? (phase == 3 ? 6 : 46) : 0;
         write_reg(REG_EXPIRE, phase == 0 ? 0 : $urandom_range(600));
         write_reg(REG_V6EN, $urandom_range(1));
         write_reg(REG_ADDR_A, $urandom);
         write_reg(REG_LEN_A, $urandom_range(40));
         write_reg(REG_ADDR_B, 32'h0A00_0000);
         write_reg(REG_LEN_B, $urandom_range(8));
         write_reg(REG_ADDR_C, $urandom);
         write_reg(REG_LEN_C, $urandom_range(63));
         if (phase == 2) stall_go = 1'b1;
         for (int i = 0; i < 250; i++) send_word(random_word());
         drain();
      end

      if (board.errors == 0)
         $display("source_abuse_score_table_test OK");
      else
         $display("source_abuse_score_table_test NOT OK");
      $finish;
   end
endmodule
